// ===== rtl/sfpd_pkg.sv =====
// Shared constants and types for the sync-framed packet deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sfpd_pkg;

    localparam int HEADER_BYTES = 28;

    localparam logic [7:0] SYNC_BYTE = 8'h23;

    localparam logic [4:0] OFF_CMD       = 5'd2;
    localparam logic [4:0] OFF_REQ       = 5'd3;
    localparam logic [4:0] OFF_COUNT_HI  = 5'd21;
    localparam logic [4:0] OFF_COUNT_LO  = 5'd22;
    localparam logic [4:0] OFF_ENC       = 5'd23;
    localparam logic [4:0] OFF_LEN_FIRST = 5'(HEADER_BYTES - 4);
    localparam logic [4:0] OFF_LAST      = 5'(HEADER_BYTES - 1);

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_BCC     = 3'd4;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [4:0]  header_position;
        logic [31:0] payload_index;
        logic        is_last;
        logic        frame_ok;
        logic [7:0]  command_id;
        logic [7:0]  request_code;
        logic [15:0] message_count;
        logic [7:0]  encryption_mode;
        logic [31:0] payload_length;
        logic [31:0] error_total;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sync_framed_packet_deframer_xor_bcc_top.sv =====
// Top level of the sync-framed packet deframer with XOR BCC check.
// Depends on sfpd_pkg, sfpd_in_stage, sfpd_core and sfpd_out_stage.
//
// Takes one received byte per cycle while in_ready is high and hunts for the
// sync pair 0x23 0x23, then passes on the 26 header bytes (kind 0) and the
// payload bytes (kind 1) and closes each frame with a frame-end word (kind 2)
// that carries the header fields, the BCC check result and the running count
// of failed frames. Sync and hunt bytes produce no output word. Throughput is
// one byte per cycle when not stalled, set by the single state update between
// the input register and the result register; a byte passes both in turn.
// Back-pressure on out_ready reaches in_ready in the same cycle only when the
// result register is full and the waiting byte would produce a word.
`timescale 1ns / 1ps
`default_nettype none

module sync_framed_packet_deframer_xor_bcc_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       byte_value,
    output logic [4:0]       header_position,
    output logic [31:0]      payload_index,
    output logic             is_last,
    output logic             frame_ok,
    output logic [7:0]       command_id,
    output logic [7:0]       request_code,
    output logic [15:0]      message_count,
    output logic [7:0]       encryption_mode,
    output logic [31:0]      payload_length,
    output logic [31:0]      error_total
);
    import sfpd_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       produce;
    logic       can_load;
    logic       advance;
    result_t    core_result;
    result_t    out_result;

    // advance a byte when it yields nothing or the result register can take it
    assign advance = held_valid && (!produce || can_load);

    sfpd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .consume    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sfpd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (held_byte),
        .advance (advance),
        .produce (produce),
        .result  (core_result)
    );

    sfpd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && produce),
        .result_in  (core_result),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (out_result)
    );

    assign kind            = out_result.kind;
    assign byte_value      = out_result.byte_value;
    assign header_position = out_result.header_position;
    assign payload_index   = out_result.payload_index;
    assign is_last         = out_result.is_last;
    assign frame_ok        = out_result.frame_ok;
    assign command_id      = out_result.command_id;
    assign request_code    = out_result.request_code;
    assign message_count   = out_result.message_count;
    assign encryption_mode = out_result.encryption_mode;
    assign payload_length  = out_result.payload_length;
    assign error_total     = out_result.error_total;

endmodule

`default_nettype wire

// ===== rtl/sfpd_in_stage.sv =====
// Input register for received bytes.
// Depends on sfpd_pkg (none of its items used beyond the import convention).
`timescale 1ns / 1ps
`default_nettype none

module sfpd_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       consume,
    output logic            held_valid,
    output logic [7:0]      held_byte
);
    import sfpd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || consume;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/sfpd_core.sv =====
// Frame state machine: sync hunt, header capture, payload count and BCC check.
// Depends on sfpd_pkg for phase codes, offsets and result_t.
`timescale 1ns / 1ps
`default_nettype none

module sfpd_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       byte_in,
    input  wire logic             advance,
    output logic                  produce,
    output sfpd_pkg::result_t     result
);
    import sfpd_pkg::*;

    logic [2:0]  phase_reg,   phase_next;
    logic [4:0]  offset_reg,  offset_next;
    logic [31:0] counter_reg, counter_next;
    logic [31:0] length_reg,  length_next;
    logic [7:0]  xor_reg,     xor_next;
    logic [7:0]  cmd_reg,     cmd_next;
    logic [7:0]  req_reg,     req_next;
    logic [15:0] count_reg,   count_next;
    logic [7:0]  enc_reg,     enc_next;
    logic [31:0] err_reg,     err_next;
    logic        bcc_ok;

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        counter_next = counter_reg;
        length_next  = length_reg;
        xor_next     = xor_reg;
        cmd_next     = cmd_reg;
        req_next     = req_reg;
        count_next   = count_reg;
        enc_next     = enc_reg;
        err_next     = err_reg;
        produce      = 1'b0;
        bcc_ok       = (byte_in == xor_reg);
        result       = '0;
        result.error_total = err_reg;

        case (phase_reg)
            PH_HUNT1:
            begin
                if (byte_in == SYNC_BYTE)
                begin
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2:
            begin
                if (byte_in == SYNC_BYTE)
                begin
                    phase_next   = PH_HEADER;
                    offset_next  = OFF_CMD;
                    xor_next     = 8'h00;
                    length_next  = 32'd0;
                    counter_next = 32'd0;
                end
                else
                begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_HEADER:
            begin
                produce  = 1'b1;
                xor_next = xor_reg ^ byte_in;
                if (offset_reg == OFF_CMD)
                begin
                    cmd_next = byte_in;
                end
                else if (offset_reg == OFF_REQ)
                begin
                    req_next = byte_in;
                end
                else if (offset_reg == OFF_COUNT_HI)
                begin
                    count_next = {byte_in, count_reg[7:0]};
                end
                else if (offset_reg == OFF_COUNT_LO)
                begin
                    count_next = {count_reg[15:8], byte_in};
                end
                else if (offset_reg == OFF_ENC)
                begin
                    enc_next = byte_in;
                end
                else if (offset_reg >= OFF_LEN_FIRST)
                begin
                    length_next = {length_reg[23:0], byte_in};
                end
                result.kind            = KIND_HEADER;
                result.byte_value      = byte_in;
                result.header_position = offset_reg;
                if (offset_reg >= OFF_LAST)
                begin
                    counter_next = 32'd0;
                    phase_next   = (length_next == 32'd0) ? PH_BCC : PH_PAYLOAD;
                    offset_next  = 5'd0;
                end
                else
                begin
                    offset_next = offset_reg + 5'd1;
                end
            end
            PH_PAYLOAD:
            begin
                produce              = 1'b1;
                xor_next             = xor_reg ^ byte_in;
                result.kind          = KIND_PAYLOAD;
                result.byte_value    = byte_in;
                result.payload_index = counter_reg;
                counter_next         = counter_reg + 32'd1;
                if (counter_next == length_reg)
                begin
                    phase_next = PH_BCC;
                end
            end
            PH_BCC:
            begin
                produce  = 1'b1;
                err_next = bcc_ok ? err_reg : err_reg + 32'd1;
                result.kind            = KIND_END;
                result.byte_value      = byte_in;
                result.is_last         = 1'b1;
                result.frame_ok        = bcc_ok;
                result.command_id      = cmd_reg;
                result.request_code    = req_reg;
                result.message_count   = count_reg;
                result.encryption_mode = enc_reg;
                result.payload_length  = length_reg;
                result.error_total     = err_next;
                phase_next   = PH_HUNT1;
                offset_next  = 5'd0;
                counter_next = 32'd0;
                xor_next     = 8'h00;
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT1;
            offset_reg  <= 5'd0;
            counter_reg <= 32'd0;
            length_reg  <= 32'd0;
            xor_reg     <= 8'h00;
            cmd_reg     <= 8'h00;
            req_reg     <= 8'h00;
            count_reg   <= 16'h0000;
            enc_reg     <= 8'h00;
            err_reg     <= 32'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            counter_reg <= counter_next;
            length_reg  <= length_next;
            xor_reg     <= xor_next;
            cmd_reg     <= cmd_next;
            req_reg     <= req_next;
            count_reg   <= count_next;
            enc_reg     <= enc_next;
            err_reg     <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfpd_out_stage.sv =====
// Result register with valid/ready toward downstream.
// Depends on sfpd_pkg for result_t.
`timescale 1ns / 1ps
`default_nettype none

module sfpd_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  sfpd_pkg::result_t      result_in,
    output logic                   can_load,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sfpd_pkg::result_t      result_out
);
    import sfpd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire
